/* rtl/gttd_pkg.sv */
// ----------------------------------------------------------------------------
// gttd_pkg : shared types and codes for the gated timed task dispatcher
// Command codes, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
package gttd_pkg;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_ENQ_FAST  = 3'd1,
		CMD_DLY_FAST  = 3'd2,
		CMD_ENQ_GATED = 3'd3,
		CMD_DLY_GATED = 3'd4,
		CMD_MAP_LOAD  = 3'd5,
		CMD_CLEAR     = 3'd6,
		CMD_NOP       = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_PR_RD,
		ST_PR_CHK,
		ST_DN_LD,
		ST_DN_CHK,
		ST_DN_L,
		ST_DN_R,
		ST_DN_CMP,
		ST_POP,
		ST_POP_RD,
		ST_EMIT0,
		ST_WAIT0,
		ST_EMIT1,
		ST_WAIT1
	} state_t;

	localparam logic [15:0] SETTLE_RESET = 16'd120;
	localparam logic [31:0] TICK_MAX     = 32'hFFFF_FFFF;

endpackage

/* rtl/gttd_ram.sv */
// ----------------------------------------------------------------------------
// gttd_ram : generic single-write RAM with registered read
// One write port and one read port, read data registered and valid in the cycle after the address.
// ----------------------------------------------------------------------------
module gttd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/gated_timed_task_dispatcher_core.sv */
// ----------------------------------------------------------------------------
// gated_timed_task_dispatcher_core : two-lane timed task dispatcher
// FIFO plus min-heap per lane, a gated lane with map flag and settle counter.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | sink      | in_valid/in_stall   | cmd task_id delay_ticks world bits
// out     | source    | out_valid/out_stall | issued_id lane last overflow
// cfg     | sink      | cfg_we              | cfg_wdata (settle_threshold)
//
// Enqueue, map load, clear and unused codes complete in the idle state.
// A delayed enqueue sifts up the heap, one level per read and compare.
// A tick promotes at most one due root per lane into its FIFO, sifting
// that heap down, pops at most one id per lane, then emits the fast
// result before the gated one. One shared compare and one read port per
// store pace the sequencer.
// Reset: all stores empty by count, no clearing pass; map_ready set.
// Stalls: a result holds in the output register until out_stall drops; the
// sequencer waits there and accepts no new item meanwhile.
// ----------------------------------------------------------------------------
module gated_timed_task_dispatcher_core #(
	parameter int FIFO_DEPTH = 16,
	parameter int HEAP_DEPTH = 16,
	parameter int ID_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [ID_BITS-1:0] task_id,
	input  logic [19:0]        delay_ticks,
	input  logic               save_loaded,
	input  logic               in_transition,
	input  logic               map_present,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ID_BITS-1:0] issued_id,
	output logic               lane,
	output logic               last,
	output logic               overflow,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import gttd_pkg::*;

	localparam int FA = $clog2(FIFO_DEPTH);
	localparam int HA = $clog2(HEAP_DEPTH);
	localparam int FC = $clog2(FIFO_DEPTH + 1);
	localparam int HC = $clog2(HEAP_DEPTH + 1);
	localparam int LW = HA + 2;
	localparam int HW = 32 + ID_BITS;

	state_t state_q, state_d;

	logic [31:0]   now_q;
	logic [15:0]   thr_q, settle_q;
	logic          map_q, ovf_q, settled_q;
	logic [FC-1:0] fcnt_q [2];
	logic [FA-1:0] hd_q [2], tl_q [2];
	logic [HC-1:0] hcnt_q [2];

	logic          ln_q;        // lane in service during a tick / insert
	logic [HA-1:0] hi_q;        // heap slot being sifted
	logic [HA-1:0] bi_q;        // slot of the earlier child
	logic [HW-1:0] cur_q;       // entry being sifted
	logic [HW-1:0] best_q;      // earlier child
	logic          fhas_q, ghas_q;
	logic [ID_BITS-1:0] fid_q, gid_q;

	// RAMs: one heap and one FIFO per lane
	logic          hwe [2];
	logic [HA-1:0] hwa [2], hra [2];
	logic [HW-1:0] hwd [2], hrd [2];
	logic          fwe [2];
	logic [FA-1:0] fwa [2], fra [2];
	logic [ID_BITS-1:0] fwd [2], frd [2];

	for (genvar g = 0; g < 2; g++) begin : g_lane
		gttd_ram #(.WIDTH(HW), .DEPTH(HEAP_DEPTH)) u_heap (
			.clk(clk), .we(hwe[g]), .waddr(hwa[g]), .wdata(hwd[g]),
			.raddr(hra[g]), .rdata(hrd[g]));
		gttd_ram #(.WIDTH(ID_BITS), .DEPTH(FIFO_DEPTH)) u_fifo (
			.clk(clk), .we(fwe[g]), .waddr(fwa[g]), .wdata(fwd[g]),
			.raddr(fra[g]), .rdata(frd[g]));
	end

	// ring pointer step
	function automatic logic [FA-1:0] fnext(input logic [FA-1:0] p);
		return (p == FA'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// shared strict compare
	logic [31:0] ca, cb;
	logic        lt;
	assign lt = ca < cb;

	cmd_t cmd_in;
	logic in_g;     // lane addressed by an enqueue
	assign cmd_in = cmd_t'(cmd);
	assign in_g   = (cmd_in == CMD_ENQ_GATED) || (cmd_in == CMD_DLY_GATED);

	logic in_acc, out_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	// saturating ready tick
	logic [32:0] rsum;
	logic [31:0] rdy;
	assign rsum = {1'b0, now_q} + {13'd0, delay_ticks};
	assign rdy  = rsum[32] ? TICK_MAX : rsum[31:0];

	logic [HC-1:0] hn;
	logic [FC-1:0] fn;
	logic [HW-1:0] hrd_l;
	logic [31:0]   hrd_rdy;
	assign hn      = hcnt_q[ln_q];
	assign fn      = fcnt_q[ln_q];
	assign hrd_l   = hrd[ln_q];
	assign hrd_rdy = hrd_l[HW-1:ID_BITS];

	logic [HA-1:0] par;
	logic [LW-1:0] lft, rgt, hn_w;
	logic          has_l, has_r;
	assign par   = (hi_q - 1'b1) >> 1;
	assign lft   = {1'b0, hi_q, 1'b1};
	assign rgt   = lft + 1'b1;
	assign hn_w  = LW'(hn);
	assign has_l = lft < hn_w;
	assign has_r = rgt < hn_w;

	logic enq_f, due, pop_go;
	assign enq_f  = in_acc && (cmd_in == CMD_ENQ_FAST || cmd_in == CMD_ENQ_GATED)
		&& (fcnt_q[in_g] < FC'(FIFO_DEPTH));
	// root due once the tick advanced, and room in the FIFO
	assign due    = (hn != '0) && !lt && (fn < FC'(FIFO_DEPTH));
	assign pop_go = (fn != '0) && settled_q && (!ln_q || (map_q && settle_q >= thr_q));

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd_in)
						CMD_DLY_FAST, CMD_DLY_GATED: begin
							if (hcnt_q[in_g] < HC'(HEAP_DEPTH))
								state_d = ST_UP_RD;
						end
						CMD_TICK: state_d = ST_PR_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_UP_RD:  state_d = (hi_q == '0) ? ST_IDLE : ST_UP_CMP;
			ST_UP_CMP: state_d = lt ? ST_UP_RD : ST_IDLE;
			ST_PR_RD:  state_d = ST_PR_CHK;
			ST_PR_CHK: state_d = due ? ST_DN_LD : ST_POP;
			ST_DN_LD:  state_d = ST_DN_CHK;
			ST_DN_CHK: state_d = has_l ? ST_DN_L : ST_POP;
			ST_DN_L:   state_d = has_r ? ST_DN_R : ST_DN_CMP;
			ST_DN_R:   state_d = ST_DN_CMP;
			ST_DN_CMP: state_d = lt ? ST_DN_CHK : ST_POP;
			ST_POP:    state_d = pop_go ? ST_POP_RD : (ln_q ? ST_EMIT0 : ST_PR_RD);
			ST_POP_RD: state_d = ln_q ? ST_EMIT0 : ST_PR_RD;
			ST_EMIT0:  state_d = fhas_q ? ST_WAIT0 : (ghas_q ? ST_WAIT1 : ST_IDLE);
			ST_WAIT0:  state_d = out_acc ? (ghas_q ? ST_EMIT1 : ST_IDLE) : ST_WAIT0;
			ST_EMIT1:  state_d = ST_WAIT1;
			ST_WAIT1:  state_d = out_acc ? ST_IDLE : ST_WAIT1;
			default:   state_d = ST_IDLE;
		endcase
	end

	// compare operand selection
	always_comb begin
		ca = cur_q[HW-1:ID_BITS];
		cb = hrd_rdy;
		unique case (state_q)
			ST_PR_CHK: begin
				ca = now_q;
				cb = hrd_rdy;
			end
			ST_DN_R: begin
				ca = hrd_rdy;
				cb = best_q[HW-1:ID_BITS];
			end
			ST_DN_CMP: begin
				ca = best_q[HW-1:ID_BITS];
				cb = cur_q[HW-1:ID_BITS];
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// RAM control
	// ------------------------------------------------------------------
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			hwe[l] = 1'b0; hwa[l] = hi_q; hwd[l] = cur_q; hra[l] = '0;
			fwe[l] = 1'b0; fwa[l] = tl_q[l]; fwd[l] = task_id; fra[l] = hd_q[l];
		end
		unique case (state_q)
			ST_IDLE: if (enq_f) fwe[in_g] = 1'b1;
			ST_UP_RD: begin
				hra[ln_q] = par;
				if (hi_q == '0) hwe[ln_q] = 1'b1;
			end
			ST_UP_CMP: begin
				hwe[ln_q] = 1'b1;
				hwd[ln_q] = lt ? hrd_l : cur_q;
			end
			ST_PR_CHK: begin
				// last entry, moved to the root on removal
				hra[ln_q] = HA'(hn - 1'b1);
				if (due) begin
					fwe[ln_q] = 1'b1;
					fwd[ln_q] = hrd_l[ID_BITS-1:0];
				end
			end
			ST_DN_CHK: begin
				hra[ln_q] = HA'(lft);
				if (!has_l) hwe[ln_q] = 1'b1;
			end
			ST_DN_L: hra[ln_q] = HA'(rgt);
			ST_DN_CMP: begin
				hwe[ln_q] = 1'b1;
				hwd[ln_q] = lt ? best_q : cur_q;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			now_q     <= '0;
			thr_q     <= SETTLE_RESET;
			settle_q  <= '0;
			map_q     <= 1'b1;
			ovf_q     <= 1'b0;
			settled_q <= 1'b0;
			fcnt_q[0] <= '0; fcnt_q[1] <= '0;
			hcnt_q[0] <= '0; hcnt_q[1] <= '0;
			hd_q[0]   <= '0; hd_q[1]   <= '0;
			tl_q[0]   <= '0; tl_q[1]   <= '0;
			ln_q      <= 1'b0;
			hi_q      <= '0;
			bi_q      <= '0;
			cur_q     <= '0;
			best_q    <= '0;
			fhas_q    <= 1'b0;
			ghas_q    <= 1'b0;
			fid_q     <= '0;
			gid_q     <= '0;
			out_valid <= 1'b0;
			issued_id <= '0;
			lane      <= 1'b0;
			last      <= 1'b0;
			overflow  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thr_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					unique case (cmd_in)
						CMD_ENQ_FAST, CMD_ENQ_GATED: begin
							if (in_g) map_q <= 1'b0;
							if (fcnt_q[in_g] < FC'(FIFO_DEPTH)) begin
								fcnt_q[in_g] <= fcnt_q[in_g] + 1'b1;
								tl_q[in_g]   <= fnext(tl_q[in_g]);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						CMD_DLY_FAST, CMD_DLY_GATED: begin
							if (in_g) map_q <= 1'b0;
							ln_q  <= in_g;
							cur_q <= {rdy, task_id};
							hi_q  <= HA'(hcnt_q[in_g]);
							if (hcnt_q[in_g] < HC'(HEAP_DEPTH))
								hcnt_q[in_g] <= hcnt_q[in_g] + 1'b1;
							else
								ovf_q <= 1'b1;
						end
						CMD_MAP_LOAD: map_q <= 1'b1;
						CMD_CLEAR: begin
							fcnt_q[0] <= '0; fcnt_q[1] <= '0;
							hcnt_q[0] <= '0; hcnt_q[1] <= '0;
							hd_q[0]   <= '0; hd_q[1]   <= '0;
							tl_q[0]   <= '0; tl_q[1]   <= '0;
							settle_q  <= '0;
						end
						CMD_TICK: begin
							if (now_q != TICK_MAX) now_q <= now_q + 1'b1;
							settled_q <= save_loaded && !in_transition && map_present;
							ln_q      <= 1'b0;
							fhas_q    <= 1'b0;
							ghas_q    <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_UP_CMP: if (lt) hi_q <= par;
				ST_PR_CHK: begin
					if (due) begin
						fcnt_q[ln_q] <= fn + 1'b1;
						tl_q[ln_q]   <= fnext(tl_q[ln_q]);
						hcnt_q[ln_q] <= hn - 1'b1;
					end
				end
				ST_DN_LD: begin
					cur_q <= hrd_l;
					hi_q  <= '0;
				end
				ST_DN_L: begin
					best_q <= hrd_l;
					bi_q   <= HA'(lft);
				end
				ST_DN_R: begin
					if (lt) begin
						best_q <= hrd_l;
						bi_q   <= HA'(rgt);
					end
				end
				ST_DN_CMP: if (lt) hi_q <= bi_q;
				ST_POP: begin
					// settle counter runs only while gated work waits
					if (ln_q && fn != '0) begin
						if (!(settled_q && map_q)) settle_q <= '0;
						else if (settle_q < thr_q) settle_q <= settle_q + 1'b1;
					end
					if (pop_go) begin
						fcnt_q[ln_q] <= fn - 1'b1;
						hd_q[ln_q]   <= fnext(hd_q[ln_q]);
						if (ln_q) ghas_q <= 1'b1;
						else fhas_q <= 1'b1;
					end else if (!ln_q) begin
						ln_q <= 1'b1;
					end
				end
				ST_POP_RD: begin
					if (ln_q) begin
						gid_q <= frd[1];
					end else begin
						fid_q <= frd[0];
						ln_q  <= 1'b1;
					end
				end
				ST_EMIT0: begin
					if (fhas_q) begin
						out_valid <= 1'b1;
						issued_id <= fid_q;
						lane      <= 1'b0;
						last      <= !ghas_q;
						overflow  <= ovf_q;
					end else if (ghas_q) begin
						out_valid <= 1'b1;
						issued_id <= gid_q;
						lane      <= 1'b1;
						last      <= 1'b1;
						overflow  <= ovf_q;
					end
				end
				ST_WAIT0: if (out_acc) out_valid <= 1'b0;
				ST_EMIT1: begin
					out_valid <= 1'b1;
					issued_id <= gid_q;
					lane      <= 1'b1;
					last      <= 1'b1;
					overflow  <= ovf_q;
				end
				ST_WAIT1: if (out_acc) out_valid <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/gttd_checker.sv */
// ----------------------------------------------------------------------------
// gttd_checker : port-level checks for the dispatcher
// Watches handshakes and result fields on the top level.
// ----------------------------------------------------------------------------
module gttd_checker #(
	parameter int ID_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [ID_BITS-1:0] issued_id,
	input logic               lane,
	input logic               last,
	input logic               overflow
);
	// overflow already shown on a taken result
	logic ovf_seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_seen_q <= 1'b0;
		end else if (out_valid && !out_stall && overflow) begin
			ovf_seen_q <= 1'b1;
		end
	end

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(issued_id) && $stable(lane)
			&& $stable(last) && $stable(overflow))
		else $error("held result changed");

	// a gated result is always the final one of its tick
	a_gated_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lane |-> last)
		else $error("gated result not last");

	// the overflow flag never falls once shown
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ovf_seen_q |-> overflow)
		else $error("overflow flag fell");

	// no input is taken while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during result");

	// a stalled input item stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled input withdrawn");
endmodule

bind gated_timed_task_dispatcher_core gttd_checker #(.ID_BITS(ID_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .issued_id(issued_id),
	.lane(lane), .last(last), .overflow(overflow));

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb : testbench for gated_timed_task_dispatcher_core
// Drives random command streams with idle and stall phases, predicts the
// dispatched ids with a behavioral model and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gttd_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [15:0] id;
		logic        ln;
		logic        lst;
		logic        ovf;
	} dispatch_t;

	typedef struct packed {
		logic [31:0] ready;
		logic [15:0] id;
	} hent_t;

	// behavioral copy of the dispatcher plus the queue of expected dispatches
	class dispatch_scoreboard;
		logic [31:0] now;
		logic [15:0] ffifo[$];
		logic [15:0] gfifo[$];
		hent_t       fheap[DEPTH];
		hent_t       gheap[DEPTH];
		int          fhn, ghn;
		logic [15:0] settle, thresh;
		bit          map_rdy, ovf;
		dispatch_t   pending[$];
		int          errors;

		function void init();
			now = '0; ffifo.delete(); gfifo.delete(); fhn = 0; ghn = 0;
			settle = '0; thresh = SETTLE_RESET; map_rdy = 1'b1; ovf = 1'b0;
			pending.delete(); errors = 0;
		endfunction

		function void heap_add(ref hent_t h[DEPTH], ref int n, input hent_t e);
			int i, p;
			hent_t t;
			if (n >= DEPTH) begin
				ovf = 1'b1;
				return;
			end
			i = n; h[i] = e; n++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (h[i].ready < h[p].ready) begin
					t = h[i]; h[i] = h[p]; h[p] = t; i = p;
				end else break;
			end
		endfunction

		function void heap_pop(ref hent_t h[DEPTH], ref int n);
			int i, l, c;
			hent_t t;
			i = 0; n--; h[0] = h[n];
			forever begin
				l = 2 * i + 1;
				if (l >= n) break;
				c = l;
				if (l + 1 < n && h[l + 1].ready < h[l].ready) c = l + 1;
				if (h[c].ready < h[i].ready) begin
					t = h[c]; h[c] = h[i]; h[i] = t; i = c;
				end else break;
			end
		endfunction

		function logic [31:0] due_at(logic [19:0] d);
			logic [32:0] s;
			s = {1'b0, now} + 33'(d);
			return s[32] ? TICK_MAX : s[31:0];
		endfunction

		function void note_transfer(cmd_t c, logic [15:0] id, logic [19:0] d,
				bit sv, bit tr, bit mp);
			bit st;
			int k0;
			k0 = pending.size();
			case (c)
				CMD_ENQ_FAST: if (ffifo.size() >= DEPTH) ovf = 1'b1; else ffifo.push_back(id);
				CMD_DLY_FAST: heap_add(fheap, fhn, '{due_at(d), id});
				CMD_ENQ_GATED: begin
					map_rdy = 1'b0;
					if (gfifo.size() >= DEPTH) ovf = 1'b1; else gfifo.push_back(id);
				end
				CMD_DLY_GATED: begin
					map_rdy = 1'b0;
					heap_add(gheap, ghn, '{due_at(d), id});
				end
				CMD_MAP_LOAD: map_rdy = 1'b1;
				CMD_CLEAR: begin
					ffifo.delete(); gfifo.delete(); fhn = 0; ghn = 0; settle = '0;
				end
				CMD_TICK: begin
					if (now != TICK_MAX) now++;
					st = sv && !tr && mp;
					if (fhn > 0 && fheap[0].ready <= now && ffifo.size() < DEPTH) begin
						ffifo.push_back(fheap[0].id); heap_pop(fheap, fhn);
					end
					if (ffifo.size() > 0 && st)
						pending.push_back('{ffifo.pop_front(), 1'b0, 1'b0, ovf});
					if (ghn > 0 && gheap[0].ready <= now && gfifo.size() < DEPTH) begin
						gfifo.push_back(gheap[0].id); heap_pop(gheap, ghn);
					end
					if (gfifo.size() > 0) begin
						if (!(st && map_rdy)) settle = '0;
						else if (settle < thresh) settle++;
						else pending.push_back('{gfifo.pop_front(), 1'b1, 1'b0, ovf});
					end
					if (pending.size() > k0) pending[pending.size() - 1].lst = 1'b1;
				end
				default: ;
			endcase
		endfunction

		task check_result(dispatch_t got);
			dispatch_t w;
			if (pending.size() == 0) begin
				report("unexpected dispatch", got, '0);
				return;
			end
			w = pending.pop_front();
			if (got.id !== w.id) report("issued_id", got, w);
			if (got.ln !== w.ln) report("lane", got, w);
			if (got.lst !== w.lst) report("last", got, w);
			if (got.ovf !== w.ovf) report("overflow", got, w);
		endtask

		task report(string what, dispatch_t got, dispatch_t want);
			errors++;
			if (errors <= 40)
				$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0, out_stall = 1'b0, cfg_we = 1'b0;
	logic        in_stall, out_valid;
	logic [2:0]  cmd = CMD_NOP;
	logic [15:0] task_id = '0, cfg_wdata = '0;
	logic [19:0] delay_ticks = '0;
	logic        save_loaded = 1'b0, in_transition = 1'b0, map_present = 1'b0;
	logic [15:0] issued_id;
	logic        lane, last, overflow;

	dispatch_scoreboard sb = new();
	int  send_idle = 0, recv_stall = 0;   // percent
	bit  hold_recv = 1'b0;
	int  quiet = 0;
	localparam int QUIET_LIMIT = 20000;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	gated_timed_task_dispatcher_core dut (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .task_id, .delay_ticks,
		.save_loaded, .in_transition, .map_present, .out_valid, .out_stall,
		.issued_id, .lane, .last, .overflow, .cfg_we, .cfg_wdata
	);

	// output sampling at rising edge; transfers feed the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_transfer(cmd_t'(cmd), task_id, delay_ticks,
					save_loaded, in_transition, map_present);
			if (out_valid && !out_stall)
				sb.check_result('{issued_id, lane, last, overflow});
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog expired");
				$display("gated_timed_task_dispatcher_core test failed");
				$finish;
			end
		end
	end

	// receiver stall, redrawn every falling edge
	always @(negedge clk)
		out_stall <= hold_recv || ($urandom_range(99) < recv_stall);

	function automatic logic [15:0] rid();
		return 16'($urandom);
	endfunction

	function automatic logic [19:0] rdl();
		return 20'($urandom);
	endfunction

	function automatic bit rb();
		return 1'($urandom);
	endfunction

	// one transfer on the input channel; valid stays high back to back unless an idle gap is drawn
	task automatic send(cmd_t c, logic [15:0] id, logic [19:0] d, bit sv, bit tr, bit mp);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1; cmd <= c; task_id <= id; delay_ticks <= d;
		save_loaded <= sv; in_transition <= tr; map_present <= mp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// wait until every expected result is out and the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0 || in_stall || out_valid) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_threshold(logic [15:0] v);
		drain();
		cfg_we <= 1'b1; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.thresh = v;
	endtask

	task automatic tick(bit settled);
		if (settled) send(CMD_TICK, rid(), rdl(), 1'b1, 1'b0, 1'b1);
		else send(CMD_TICK, rid(), rdl(), rb(), rb(), rb());
	endtask

	// random item biased toward well-formed enqueue/tick traffic
	task automatic random_item();
		int r;
		logic [19:0] d;
		r = int'($urandom_range(99));
		d = ($urandom_range(9) == 0) ? rdl() : 20'($urandom_range(6));
		if (r < 45) tick($urandom_range(9) != 0);
		else if (r < 57) send(CMD_ENQ_FAST, rid(), rdl(), rb(), rb(), rb());
		else if (r < 67) send(CMD_DLY_FAST, rid(), d, rb(), rb(), rb());
		else if (r < 77) send(CMD_ENQ_GATED, rid(), rdl(), rb(), rb(), rb());
		else if (r < 85) send(CMD_DLY_GATED, rid(), d, rb(), rb(), rb());
		else if (r < 95) send(CMD_MAP_LOAD, rid(), rdl(), rb(), rb(), rb());
		else if (r < 98) send(CMD_CLEAR, rid(), rdl(), rb(), rb(), rb());
		else send(CMD_NOP, rid(), rdl(), rb(), rb(), rb());
	endtask

	initial begin
		int ph;
		sb.init();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset threshold, extremes, delays 0 and maximum, overflow
		send(CMD_ENQ_FAST, 16'hFFFF, 20'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_DLY_FAST, 16'h0000, 20'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_DLY_FAST, 16'h1234, 20'hFFFFF, 1'b0, 1'b0, 1'b0);
		tick(1'b1);
		tick(1'b1);
		send(CMD_ENQ_GATED, 16'hA5A5, 20'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_MAP_LOAD, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);
		repeat (3) tick(1'b1);
		send(CMD_NOP, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b1, 1'b1);
		tick(1'b0);
		send(CMD_CLEAR, 16'd0, 20'd0, 1'b1, 1'b1, 1'b1);
		set_threshold(16'd0);
		for (int i = 0; i < 18; i++) send(CMD_ENQ_FAST, 16'(i), 20'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_ENQ_GATED, 16'h00FF, 20'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_MAP_LOAD, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);
		tick(1'b1);
		tick(1'b1);
		send(CMD_CLEAR, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);

		// long receiver hold-off while the sender keeps offering ticks
		for (int i = 0; i < 8; i++) send(CMD_ENQ_FAST, 16'(i + 100), 20'd0, 1'b0, 1'b0, 1'b0);
		hold_recv = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 8; i++) tick(1'b1);
		join
		drain();   // sender pause until everything is out

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 51; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 51; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			case (ph)
				0: set_threshold(16'd0);
				1: set_threshold(16'd1);
				2: set_threshold(16'd3);
				3: set_threshold(16'($urandom_range(8)));
				7: set_threshold(16'hFFFF);
				default: set_threshold(16'd2);
			endcase
			for (int i = 0; i < 215; i++) random_item();
		end

		send_idle = 0; recv_stall = 0;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("gated_timed_task_dispatcher_core test passed");
		else
			$display("gated_timed_task_dispatcher_core test failed");
		$finish;
	end
endmodule
